[src/rv32i_instruction_step_top_macros.svh]
// assertion helpers for the core
`ifndef RV32I_INSTRUCTION_STEP_TOP_MACROS_SVH
`define RV32I_INSTRUCTION_STEP_TOP_MACROS_SVH

// same-cycle implication
`define RVIS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvis assertion failed");

// next-cycle implication
`define RVIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvis assertion failed");

`endif

[src/rvis_pkg.sv]
`timescale 1ns / 1ps
package rvis_pkg;

  // byte memory size, a power of two so addresses wrap by masking
  localparam int MEM_BYTES = 65536;

  typedef logic [3:0] alu_op_t;

  localparam alu_op_t ALU_ADD  = 4'd0;
  localparam alu_op_t ALU_SUB  = 4'd1;
  localparam alu_op_t ALU_SLL  = 4'd2;
  localparam alu_op_t ALU_SLT  = 4'd3;
  localparam alu_op_t ALU_SLTU = 4'd4;
  localparam alu_op_t ALU_XOR  = 4'd5;
  localparam alu_op_t ALU_SRL  = 4'd6;
  localparam alu_op_t ALU_SRA  = 4'd7;
  localparam alu_op_t ALU_OR   = 4'd8;
  localparam alu_op_t ALU_AND  = 4'd9;

  localparam logic [6:0] OPC_LUI    = 7'b011_0111;
  localparam logic [6:0] OPC_AUIPC  = 7'b001_0111;
  localparam logic [6:0] OPC_JAL    = 7'b110_1111;
  localparam logic [6:0] OPC_JALR   = 7'b110_0111;
  localparam logic [6:0] OPC_LOAD   = 7'b000_0011;
  localparam logic [6:0] OPC_OPIMM  = 7'b001_0011;
  localparam logic [6:0] OPC_BRANCH = 7'b110_0011;
  localparam logic [6:0] OPC_STORE  = 7'b010_0011;
  localparam logic [6:0] OPC_OP     = 7'b011_0011;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [31:0] HALT_WORD = 32'h0ff0_0513;

  // true when the word is one of the supported rv32i instructions
  function automatic logic is_legal(input logic [31:0] ir);
    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    logic       ok;
    opc = ir[6:0];
    f3  = ir[14:12];
    f7  = ir[31:25];
    case (opc)
      OPC_LUI, OPC_AUIPC, OPC_JAL: ok = 1'b1;
      OPC_JALR:   ok = (f3 == 3'd0);
      OPC_BRANCH: ok = (f3 != 3'd2) && (f3 != 3'd3);
      OPC_LOAD:   ok = (f3 != 3'd3) && (f3 != 3'd6) && (f3 != 3'd7);
      OPC_STORE:  ok = (f3 <= 3'd2);
      OPC_OPIMM: begin
        if (f3 == 3'd1) ok = (f7 == F7_BASE);
        else if (f3 == 3'd5) ok = (f7 == F7_BASE) || (f7 == F7_ALT);
        else ok = 1'b1;
      end
      OPC_OP: begin
        if (f7 == F7_BASE) ok = 1'b1;
        else if (f7 == F7_ALT) ok = (f3 == 3'd0) || (f3 == 3'd5);
        else ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

[src/rvis_alu.sv]
`timescale 1ns / 1ps
module rvis_alu import rvis_pkg::*; (
  input  alu_op_t     op,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic [31:0] r
);

  always_comb begin
    case (op)
      ALU_ADD:  r = x + y;
      ALU_SUB:  r = x - y;
      ALU_SLL:  r = x << y[4:0];
      ALU_SLT:  r = {31'd0, $signed(x) < $signed(y)};
      ALU_SLTU: r = {31'd0, x < y};
      ALU_XOR:  r = x ^ y;
      ALU_SRL:  r = x >> y[4:0];
      ALU_SRA:  r = $unsigned($signed(x) >>> y[4:0]);
      ALU_OR:   r = x | y;
      ALU_AND:  r = x & y;
      default:  r = 32'd0;
    endcase
  end

endmodule

[src/rv32i_instruction_step_top.sv]
// rv32i core: one instruction per step beat, one result beat per input beat, one in flight
// byte write: write, then result; step: fetch four bytes, result at once if halted, invalid
// or stopped, else read rs1, rs2, execute, next pc, then store, load and write back, write
// back, or (branch) result; byte-wide accesses through the single-port byte memory and one
// shared alu; next input can be taken the cycle after the result beat unless cfg_valid is high
// reset (rst_n low, synchronous) makes registers read as zero, zeroes pc, then a clearing pass zeroes memory
`timescale 1ns / 1ps
`include "rv32i_instruction_step_top_macros.svh"
module rv32i_instruction_step_top import rvis_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // load_addr[15:0], load_byte[23:16]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  // pc_out[15:0], instr_word[47:16], halted[48], invalid[49], return_value[81:50]
  output logic [87:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] MEM_LAST = AW'(MEM_BYTES - 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WRB   = 4'd3;
  localparam logic [3:0] S_FETCH = 4'd4;
  localparam logic [3:0] S_RS1   = 4'd5;
  localparam logic [3:0] S_RS2   = 4'd6;
  localparam logic [3:0] S_EXEC  = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_LOAD  = 4'd9;
  localparam logic [3:0] S_STORE = 4'd10;
  localparam logic [3:0] S_WB    = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]    state_r;
  logic [5:0]    cnt_r;
  logic [AW-1:0] clr_r, addr_r;
  logic [15:0]   pc_r, out_pc_r;
  logic [31:0]   ir_r, a_r, b_r, res_r, ld_r, a0_r;
  logic [7:0]    byte_r;
  logic          take_r, stopped_r, inv_r;

  // byte memory and register file
  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  mem_q;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]  mem_wd;
  logic [31:0] rf [32];
  logic [31:0] rf_q;
  logic [31:0] rfv_r;
  logic        rfv_q;
  logic [4:0]  rf_ra;
  logic        rf_we;
  logic [31:0] wb_val;

  // decode fields
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [4:0]  rd, rs1, rs2;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic [31:0] b_cur, ir_full;
  logic [15:0] link;
  logic [2:0]  nbytes;

  // shared alu
  alu_op_t     alu_op;
  logic [31:0] alu_x, alu_y, alu_r;

  // next byte address, wraps at the top of memory
  logic [AW-1:0] addr_step;

  assign opc = ir_r[6:0];
  assign f3  = ir_r[14:12];
  assign rd  = ir_r[11:7];
  assign rs1 = ir_r[19:15];
  assign rs2 = ir_r[24:20];
  assign imm_i = {{20{ir_r[31]}}, ir_r[31:20]};
  assign imm_s = {{20{ir_r[31]}}, ir_r[31:25], ir_r[11:7]};
  assign imm_b = {{19{ir_r[31]}}, ir_r[31], ir_r[7], ir_r[30:25], ir_r[11:8], 1'b0};
  assign imm_u = {ir_r[31:12], 12'd0};
  assign imm_j = {{11{ir_r[31]}}, ir_r[31], ir_r[19:12], ir_r[20], ir_r[30:21], 1'b0};
  assign link  = pc_r + 16'd4;
  assign b_cur = rfv_q ? rf_q : 32'd0;
  assign ir_full = {mem_q, ir_r[31:8]};
  assign nbytes = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;

  assign addr_step = (addr_r == MEM_LAST) ? '0 : addr_r + 1'b1;

  // alu operand selection: exec computes the result, next computes the new pc
  always_comb begin
    alu_op = ALU_ADD;
    alu_x  = a_r;
    alu_y  = b_cur;
    if (state_r == S_NEXT) begin
      alu_op = ALU_ADD;
      alu_x  = (opc == OPC_JALR) ? a_r : {16'd0, pc_r};
      if (opc == OPC_JAL) alu_y = imm_j;
      else if (opc == OPC_JALR) alu_y = imm_i;
      else if (opc == OPC_BRANCH && take_r) alu_y = imm_b;
      else alu_y = 32'd4;
    end else begin
      case (opc)
        OPC_LUI: begin
          alu_x = 32'd0;
          alu_y = imm_u;
        end
        OPC_AUIPC: begin
          alu_x = {16'd0, pc_r};
          alu_y = imm_u;
        end
        OPC_LOAD:  alu_y = imm_i;
        OPC_STORE: alu_y = imm_s;
        OPC_BRANCH: begin
          if (f3[2:1] == 2'b00) alu_op = ALU_XOR;
          else if (f3[1]) alu_op = ALU_SLTU;
          else alu_op = ALU_SLT;
        end
        OPC_OPIMM, OPC_OP: begin
          if (opc == OPC_OPIMM) alu_y = imm_i;
          case (f3)
            3'd0: alu_op = (opc == OPC_OP && ir_r[30]) ? ALU_SUB : ALU_ADD;
            3'd1: alu_op = ALU_SLL;
            3'd2: alu_op = ALU_SLT;
            3'd3: alu_op = ALU_SLTU;
            3'd4: alu_op = ALU_XOR;
            3'd5: alu_op = ir_r[30] ? ALU_SRA : ALU_SRL;
            3'd6: alu_op = ALU_OR;
            default: alu_op = ALU_AND;
          endcase
        end
        default: alu_op = ALU_ADD;
      endcase
    end
  end

  rvis_alu u_alu (
    .op (alu_op),
    .x  (alu_x),
    .y  (alu_y),
    .r  (alu_r)
  );

  // memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = byte_r;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = 8'd0;
      end
      S_WRB:   mem_we = 1'b1;
      S_STORE: begin
        mem_we = 1'b1;
        mem_wd = b_r[7:0];
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[addr_r];
  end

  // load result extension; other instructions write back res_r
  always_comb begin
    case (f3)
      3'd0: wb_val = {{24{ld_r[31]}}, ld_r[31:24]};
      3'd1: wb_val = {{16{ld_r[31]}}, ld_r[31:16]};
      3'd4: wb_val = {24'd0, ld_r[31:24]};
      3'd5: wb_val = {16'd0, ld_r[31:16]};
      default: wb_val = ld_r;
    endcase
    if (opc != OPC_LOAD) wb_val = res_r;
  end

  assign rf_ra = (state_r == S_RS1) ? rs1 : rs2;
  assign rf_we = (state_r == S_WB) && (rd != 5'd0);

  always_ff @(posedge clk) begin
    if (rf_we) rf[rd] <= wb_val;
    rf_q <= rf[rf_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rfv_r <= '0;
      rfv_q <= 1'b0;
    end else begin
      if (rf_we) rfv_r[rd] <= 1'b1;
      rfv_q <= rfv_r[rf_ra];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      cnt_r     <= '0;
      clr_r     <= '0;
      pc_r      <= '0;
      stopped_r <= 1'b0;
      inv_r     <= 1'b0;
      a0_r      <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == MEM_LAST) state_r <= S_IDLE;
        end
        S_IDLE: begin
          // boot address write only lands while nothing is in flight
          if (cfg_valid && cfg_ready) pc_r <= cfg_data;
          if (in_tvalid && in_tready) begin
            inv_r <= 1'b0;
            cnt_r <= '0;
            // memory size is a power of two, so the address wrap is the low bits
            if (in_tuser) begin
              out_pc_r <= pc_r;
              addr_r   <= pc_r;
              state_r  <= S_FETCH;
            end else begin
              out_pc_r <= '0;
              ir_r     <= '0;
              byte_r   <= in_tdata[23:16];
              addr_r   <= in_tdata[15:0];
              state_r  <= S_WRB;
            end
          end
        end
        S_WRB: state_r <= S_OUT;
        // issue four byte reads, shift each returning byte in from the top
        S_FETCH: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r < 6'd4) addr_r <= addr_step;
          if (cnt_r != 6'd0) ir_r <= ir_full;
          if (cnt_r == 6'd4) begin
            if (stopped_r) begin
              state_r <= S_OUT;
            end else if (ir_full == HALT_WORD) begin
              stopped_r <= 1'b1;
              state_r   <= S_OUT;
            end else if (!is_legal(ir_full)) begin
              stopped_r <= 1'b1;
              inv_r     <= 1'b1;
              state_r   <= S_OUT;
            end else begin
              state_r <= S_RS1;
            end
          end
        end
        S_RS1: state_r <= S_RS2;
        S_RS2: begin
          a_r     <= b_cur;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          b_r <= b_cur;
          if (opc == OPC_JAL || opc == OPC_JALR) res_r <= {16'd0, link};
          else res_r <= alu_r;
          if (f3[2:1] == 2'b00) take_r <= (alu_r == 32'd0) ^ f3[0];
          else take_r <= alu_r[0] ^ f3[0];
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          pc_r <= (opc == OPC_JALR) ? {alu_r[15:1], 1'b0} : alu_r[15:0];
          cnt_r  <= '0;
          addr_r <= res_r[AW-1:0];
          if (opc == OPC_LOAD) begin
            state_r <= S_LOAD;
          end else if (opc == OPC_STORE) begin
            state_r <= S_STORE;
          end else if (opc == OPC_BRANCH) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_WB;
          end
        end
        S_LOAD: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r < {3'd0, nbytes}) addr_r <= addr_step;
          if (cnt_r != 6'd0) ld_r <= {mem_q, ld_r[31:8]};
          if (cnt_r == {3'd0, nbytes}) state_r <= S_WB;
        end
        S_STORE: begin
          cnt_r  <= cnt_r + 1'b1;
          addr_r <= addr_step;
          b_r    <= {8'd0, b_r[31:8]};
          if (cnt_r == {3'd0, nbytes} - 6'd1) state_r <= S_OUT;
        end
        S_WB: begin
          if (rd == 5'd10) a0_r <= wb_val;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a pending boot address write holds off the input beat
  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign out_tvalid = (state_r == S_OUT);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tdata  = {6'd0, a0_r, inv_r, stopped_r, ir_r, out_pc_r};

  // checks
  `RVIS_ASSERT_IMP(a_one_at_a_time, in_tready, !out_tvalid)
  `RVIS_ASSERT_IMP(a_invalid_halts, out_tvalid && inv_r, stopped_r)
  `RVIS_ASSERT_IMP(a_x0_never_written, 1'b1, !rfv_r[0])
  `RVIS_ASSERT_NEXT(a_ready_after_out, out_tvalid && out_tready, state_r == S_IDLE)

endmodule

[tb/sv/rvis_tb_pkg.sv]
`timescale 1ns / 1ps
package rvis_tb_pkg;

  // input beat kind carried on in_tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // opcodes outside the supported subset
  localparam logic [6:0] OPC_FENCE  = 7'b000_1111;
  localparam logic [6:0] OPC_SYSTEM = 7'b111_0011;

  // alu funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // load and store funct3
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_SB  = 3'd0;
  localparam logic [2:0] F3_SW  = 3'd2;

  // result beat, same layout as out_tdata[81:0]
  typedef struct packed {
    logic [31:0] a0;
    logic        inv;
    logic        halted;
    logic [31:0] instr;
    logic [15:0] pc;
  } step_result_t;

endpackage

[tb/sv/rv32i_step_checker.sv]
`timescale 1ns / 1ps
module rv32i_step_checker import rvis_pkg::*; import rvis_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output logic [15:0] pc_now,
  output logic        core_stopped
);

  logic [31:0]  gpr [32] = '{default: 32'd0};
  logic [7:0]   mem_img [65536] = '{default: 8'd0};
  logic [15:0]  pc_q = '0;
  logic         stop_q = 1'b0;
  int           err_cnt = 0;
  step_result_t result_q [$];

  // little-endian read, each byte address wraps on its own
  function automatic logic [31:0] read_le(input logic [31:0] addr, input int n);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < n; k++) v |= 32'(mem_img[16'(addr + k)]) << (8 * k);
    return v;
  endfunction

  task automatic exec_word(input logic [31:0] ir, output bit ok);
    logic [31:0] a, b, val, immi, imm, nxt, addr, tmp, link;
    logic [4:0]  rd, sh;
    logic [2:0]  f3;
    logic [6:0]  f7;
    bit          wb, take;
    ok = 1'b1;
    wb = 1'b0;
    take = 1'b0;
    val = '0;
    rd = ir[11:7];
    f3 = ir[14:12];
    f7 = ir[31:25];
    a = gpr[ir[19:15]];
    b = gpr[ir[24:20]];
    immi = {{20{ir[31]}}, ir[31:20]};
    nxt = {16'd0, pc_q} + 32'd4;
    link = {16'd0, 16'(pc_q + 16'd4)};
    case (ir[6:0])
      OPC_LUI: begin
        val = {ir[31:12], 12'd0};
        wb = 1'b1;
      end
      OPC_AUIPC: begin
        val = {16'd0, pc_q} + {ir[31:12], 12'd0};
        wb = 1'b1;
      end
      OPC_JAL: begin
        imm = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
        val = link;
        wb = 1'b1;
        nxt = {16'd0, pc_q} + imm;
      end
      OPC_JALR: begin
        if (f3 != F3_ADD) ok = 1'b0;
        else begin
          val = link;
          wb = 1'b1;
          nxt = (a + immi) & ~32'd1;
        end
      end
      OPC_BRANCH: begin
        imm = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
        case (f3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = ($signed(a) < $signed(b));
          F3_BGE:  take = !($signed(a) < $signed(b));
          F3_BLTU: take = (a < b);
          F3_BGEU: take = (a >= b);
          default: ok = 1'b0;
        endcase
        if (take) nxt = {16'd0, pc_q} + imm;
      end
      OPC_LOAD: begin
        addr = a + immi;
        wb = 1'b1;
        case (f3)
          F3_LB: begin
            tmp = read_le(addr, 1);
            val = {{24{tmp[7]}}, tmp[7:0]};
          end
          F3_LH: begin
            tmp = read_le(addr, 2);
            val = {{16{tmp[15]}}, tmp[15:0]};
          end
          F3_LW:  val = read_le(addr, 4);
          F3_LBU: val = read_le(addr, 1);
          F3_LHU: val = read_le(addr, 2);
          default: ok = 1'b0;
        endcase
      end
      OPC_STORE: begin
        addr = a + {{20{ir[31]}}, ir[31:25], ir[11:7]};
        if (f3 > F3_SW) ok = 1'b0;
        else for (int k = 0; k < (1 << f3); k++) mem_img[16'(addr + k)] = b[8 * k +: 8];
      end
      OPC_OPIMM: begin
        sh = ir[24:20];
        wb = 1'b1;
        case (f3)
          F3_ADD:  val = a + immi;
          F3_SLT:  val = {31'd0, $signed(a) < $signed(immi)};
          F3_SLTU: val = {31'd0, a < immi};
          F3_XOR:  val = a ^ immi;
          F3_OR:   val = a | immi;
          F3_AND:  val = a & immi;
          F3_SLL: begin
            if (f7 != F7_BASE) ok = 1'b0;
            else val = a << sh;
          end
          default: begin
            if (f7 == F7_BASE) val = a >> sh;
            else if (f7 == F7_ALT) val = $signed(a) >>> sh;
            else ok = 1'b0;
          end
        endcase
      end
      OPC_OP: begin
        sh = b[4:0];
        wb = 1'b1;
        if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) val = a - b;
          else if (f3 == F3_SR) val = $signed(a) >>> sh;
          else ok = 1'b0;
        end else if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  val = a + b;
            F3_SLL:  val = a << sh;
            F3_SLT:  val = {31'd0, $signed(a) < $signed(b)};
            F3_SLTU: val = {31'd0, a < b};
            F3_XOR:  val = a ^ b;
            F3_SR:   val = a >> sh;
            F3_OR:   val = a | b;
            default: val = a & b;
          endcase
        end else ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase
    if (ok) begin
      if (wb && rd != 5'd0) gpr[rd] = val;
      pc_q = nxt[15:0];
    end
  endtask

  always @(posedge clk) begin : watch
    logic [31:0]  ir;
    bit           ok;
    step_result_t exp_r, got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) pc_q = cfg_data;
      if (in_tvalid && in_tready) begin
        exp_r = '0;
        if (in_tuser == OP_BYTE) mem_img[in_tdata[15:0]] = in_tdata[23:16];
        else begin
          exp_r.pc = pc_q;
          ir = read_le({16'd0, pc_q}, 4);
          exp_r.instr = ir;
          if (!stop_q) begin
            if (ir == HALT_WORD) stop_q = 1'b1;
            else begin
              exec_word(ir, ok);
              if (!ok) begin
                stop_q = 1'b1;
                exp_r.inv = 1'b1;
              end
            end
          end
        end
        exp_r.halted = stop_q;
        exp_r.a0 = gpr[10];
        result_q.push_back(exp_r);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[81:0];
        if (result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0t] result beat with nothing outstanding: %h", $realtime, got);
        end else begin
          exp_r = result_q.pop_front();
          if (got !== exp_r) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("[%0t] mismatch pc %h/%h instr %h/%h halted %b/%b (exp/act)",
                       $realtime, exp_r.pc, got.pc, exp_r.instr, got.instr,
                       exp_r.halted, got.halted);
              $display("  invalid %b/%b a0 %h/%h (exp/act)",
                       exp_r.inv, got.inv, exp_r.a0, got.a0);
            end
          end
        end
      end
    end
    mismatches <= err_cnt;
    pending <= result_q.size();
    pc_now <= pc_q;
    core_stopped <= stop_q;
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top import rvis_pkg::*; import rvis_tb_pkg::*;;

  // idle cycles with no accepted beat before giving up; set to outlast the clearing pass after reset
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int SETTLE_CYCLES  = 200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  int          mismatches;
  int          pending;
  logic [15:0] pc_now;
  logic        core_stopped;

  logic        idle_on;
  int          stall_left = 0;
  int          idle_cycles = 0;
  int          n_bytes;
  int          n_steps;
  int          n_boot;

  rv32i_instruction_step_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  rv32i_step_checker step_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .pc_now       (pc_now),
    .core_stopped (core_stopped)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // gap lengths: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= gap_len();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles where no channel moves a beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("rv32i_instruction_step_top regression: fail");
      $finish;
    end
  end

  // one beat on the input channel; returns in the step of the accepting edge
  task automatic send_beat(input logic op, input logic [15:0] addr, input logic [7:0] data);
    int gap;
    gap = idle_on ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {data, addr};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    if (op == OP_BYTE) n_bytes++;
    else n_steps++;
  endtask

  // place a word at the current pc, byte by byte, then execute it
  task automatic step_word(input logic [31:0] w);
    logic [15:0] at;
    in_tvalid <= 1'b0;
    @(negedge clk);
    at = pc_now;
    @(posedge clk);
    for (int k = 0; k < 4; k++) send_beat(OP_BYTE, 16'(at + k), w[8 * k +: 8]);
    // address and byte fields are don't-care on a step, keep them toggling
    send_beat(OP_STEP, 16'($urandom), 8'($urandom));
  endtask

  // boot address write, only once the core has drained
  task automatic write_boot(input logic [15:0] v);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    n_boot++;
  endtask

  // favor a0 so the reported register moves often
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return 5'd10;
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] legal_word();
    logic [2:0]  br_f3 [6];
    logic [2:0]  ld_f3 [5];
    logic [31:0] r;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    br_f3 = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU};
    ld_f3 = '{F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU};
    r = $urandom;
    rd = pick_reg();
    rs1 = pick_reg();
    rs2 = pick_reg();
    case ($urandom_range(0, 9))
      0: return {r[31:12], rd, OPC_LUI};
      1: return {r[31:12], rd, OPC_AUIPC};
      2: return {r[31:12], rd, OPC_JAL};
      3: return {r[31:20], rs1, F3_ADD, rd, OPC_JALR};
      4: return {r[31:25], rs2, rs1, br_f3[$urandom_range(0, 5)], r[11:7], OPC_BRANCH};
      5: return {r[31:20], rs1, ld_f3[$urandom_range(0, 4)], rd, OPC_LOAD};
      6: return {r[31:25], rs2, rs1, 3'($urandom_range(0, 2)), r[11:7], OPC_STORE};
      7: begin
        f3 = 3'($urandom_range(0, 7));
        if (f3 == F3_SLL) return {F7_BASE, r[24:20], rs1, f3, rd, OPC_OPIMM};
        if (f3 == F3_SR)
          return {r[0] ? F7_ALT : F7_BASE, r[24:20], rs1, f3, rd, OPC_OPIMM};
        return {r[31:20], rs1, f3, rd, OPC_OPIMM};
      end
      default: begin
        f3 = 3'($urandom_range(0, 7));
        f7 = ((f3 == F3_ADD || f3 == F3_SR) && r[0]) ? F7_ALT : F7_BASE;
        return {f7, rs2, rs1, f3, rd, OPC_OP};
      end
    endcase
  endfunction

  // one of ten flavors of undecodable word
  function automatic logic [31:0] illegal_word();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {r[31:7], OPC_FENCE};
      2: return {r[31:7], OPC_SYSTEM};
      3: return {r[31:15], 3'($urandom_range(1, 7)), r[11:7], OPC_JALR};
      4: return {r[31:15], r[0] ? F3_SLT : F3_SLTU, r[11:7], OPC_BRANCH};
      5: return {r[31:15], r[0] ? F3_SLTU : (r[1] ? F3_OR : F3_AND), r[11:7], OPC_LOAD};
      6: return {r[31:15], 3'($urandom_range(3, 7)), r[11:7], OPC_STORE};
      7: return {r[31:25] | 7'h01, r[24:15], r[1] ? F3_SLL : F3_SR, r[11:7], OPC_OPIMM};
      8: return {r[31:25] | 7'h40, r[24:7], OPC_OP};
      default: return {F7_ALT, r[24:15], r[0] ? F3_XOR : F3_AND, r[11:7], OPC_OP};
    endcase
  endfunction

  initial begin
    int target;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_BYTE;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_on = 1'b1;
    n_bytes = 0;
    n_steps = 0;
    n_boot = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: a0 through lui, addi -1, full arithmetic shift and negate
    step_word({20'hFFFFF, 5'd10, OPC_LUI});
    step_word({12'hFFF, 5'd10, F3_ADD, 5'd10, OPC_OPIMM});
    step_word({F7_ALT, 5'd31, 5'd10, F3_SR, 5'd10, OPC_OPIMM});
    step_word({F7_ALT, 5'd10, 5'd0, F3_ADD, 5'd10, OPC_OP});
    // byte writes at both ends of memory with extreme data
    send_beat(OP_BYTE, 16'hFFFF, 8'hFF);
    send_beat(OP_BYTE, 16'h0000, 8'h00);

    // random phases, each from its own boot address; the first two fetch
    // across the top of memory
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_boot(16'hFFFE);
        1: write_boot(16'hFFFF);
        2: write_boot(16'h0000);
        default: write_boot(16'($urandom));
      endcase
      idle_on <= (ph != 2);
      target = n_bytes + n_steps + 195;
      while (n_bytes + n_steps < target) begin
        // stray byte writes as noise, otherwise place and run a legal word
        if ($urandom_range(0, 99) < 15) send_beat(OP_BYTE, 16'($urandom), 8'($urandom));
        else step_word(legal_word());
      end
    end

    // stop the core for good: halt word or an undecodable word
    idle_on <= 1'b1;
    if ($urandom_range(0, 1) == 0) step_word(HALT_WORD);
    else step_word(illegal_word());
    // steps and byte writes while stopped
    send_beat(OP_STEP, 16'($urandom), 8'($urandom));
    send_beat(OP_BYTE, 16'($urandom), 8'($urandom));
    step_word(legal_word());
    send_beat(OP_STEP, 16'($urandom), 8'($urandom));

    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d program byte writes and %0d instruction steps", n_bytes, n_steps);
    $display("across %0d boot addresses, core stopped at end: %b, mismatches: %0d",
             n_boot, core_stopped, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("rv32i_instruction_step_top regression: pass");
    end else begin
      $display("rv32i_instruction_step_top regression: fail");
    end
    $finish;
  end

endmodule
